// File: design/mfrf_pkg.sv
`default_nettype none

package mfrf_pkg;

    // duplicate cache geometry
    localparam int CACHE_DEPTH = 16;
    localparam int PTR_W       = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

    // frame size limits
    localparam logic [8:0] HEADER_BYTES  = 9'd6;
    localparam logic [8:0] PHONE_MAX_LEN = 9'd254;
    localparam logic [8:0] RELAY_MAX_LEN = 9'd256;
    localparam logic [7:0] TEAM_MIN_BODY = 8'd2;

    // verdict codes
    localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
    localparam logic [1:0] VERDICT_SHORT  = 2'd1;
    localparam logic [1:0] VERDICT_OWN    = 2'd2;
    localparam logic [1:0] VERDICT_DUP    = 2'd3;

    // register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_TEAM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHONE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_ON    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STATE_CODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 3'd5;

    typedef struct packed {
        logic [7:0]  frame_type;
        logic [7:0]  origin_node;
        logic [15:0] sequence_req;
        logic [7:0]  hops_left;
        logic [7:0]  body_length;
        logic [7:0]  sender_team;
        logic [8:0]  frame_length;
    } frame_word_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic       to_phone;
        logic       do_relay;
        logic [7:0] relay_hops;
        logic       start_deliver;
    } result_word_t;

    typedef struct packed {
        logic [7:0] own_node_id;
        logic [7:0] own_team_id;
        logic       phone_linked;
        logic       start_handler_on;
        logic [7:0] state_type_code;
        logic [7:0] start_type_code;
    } cfg_t;

    // cache scan status back to the sequencer
    typedef struct packed {
        logic done;
        logic hit;
    } scan_status_t;

endpackage

`default_nettype wire

// File: design/mfrf_cache.sv
`default_nettype none

module mfrf_cache (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [7:0]            origin,
    input  wire logic [15:0]           sequence_req,
    output mfrf_pkg::scan_status_t     status
);

    // entry storage, no reset: only read behind a valid bit
    logic [7:0]  origin_mem [mfrf_pkg::CACHE_DEPTH];
    logic [15:0] seq_mem    [mfrf_pkg::CACHE_DEPTH];

    logic [mfrf_pkg::CACHE_DEPTH-1:0] valid_reg;
    logic [mfrf_pkg::PTR_W-1:0]       idx_reg;
    logic [mfrf_pkg::PTR_W-1:0]       ptr_reg;
    logic                             scan_reg;

    logic match;
    logic last;
    logic insert;

    // one entry compared per cycle
    assign match  = scan_reg && valid_reg[idx_reg]
                    && (origin_mem[idx_reg] == origin)
                    && (seq_mem[idx_reg] == sequence_req);
    assign last   = (idx_reg == mfrf_pkg::PTR_W'(mfrf_pkg::CACHE_DEPTH - 1));
    assign insert = scan_reg && last && !match;

    assign status.done = scan_reg && (match || last);
    assign status.hit  = match;

    // scan sequencer and ring pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg  <= 1'b0;
            idx_reg   <= '0;
            ptr_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            if (start)
            begin
                scan_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (scan_reg)
            begin
                if (match || last)
                    scan_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 1'b1;
            end
            if (insert)
            begin
                valid_reg[ptr_reg] <= 1'b1;
                if (ptr_reg == mfrf_pkg::PTR_W'(mfrf_pkg::CACHE_DEPTH - 1))
                    ptr_reg <= '0;
                else
                    ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    // new pair written at the ring pointer
    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            origin_mem[ptr_reg] <= origin;
            seq_mem[ptr_reg]    <= sequence_req;
        end
    end

endmodule

`default_nettype wire

// File: design/mfrf_decide.sv
`default_nettype none

module mfrf_decide (
    input  wire mfrf_pkg::frame_word_t  frame,
    input  wire mfrf_pkg::cfg_t         cfg,
    input  wire logic [1:0]             verdict,
    output mfrf_pkg::result_word_t      result
);

    logic       ok;
    logic       blocked;
    logic       start_hit;
    logic       phone;
    logic       relay;
    logic [9:0] need_len;

    // frame needs header plus body to reach the start handler
    assign need_len = 10'(mfrf_pkg::HEADER_BYTES) + 10'(frame.body_length);

    // player-state privacy filter
    assign blocked = (frame.frame_type == cfg.state_type_code)
                     && (frame.body_length >= mfrf_pkg::TEAM_MIN_BODY)
                     && (frame.sender_team != cfg.own_team_id);

    assign ok        = (verdict == mfrf_pkg::VERDICT_ACCEPT);
    assign start_hit = ok && (frame.frame_type == cfg.start_type_code)
                       && cfg.start_handler_on
                       && (need_len <= 10'(frame.frame_length));
    assign phone     = ok && !blocked && cfg.phone_linked
                       && (frame.frame_length <= mfrf_pkg::PHONE_MAX_LEN);
    assign relay     = ok && !blocked && (frame.hops_left != 8'd0)
                       && (frame.frame_length <= mfrf_pkg::RELAY_MAX_LEN);

    always_comb
    begin
        result.verdict       = verdict;
        result.to_phone      = phone;
        result.do_relay      = relay;
        result.relay_hops    = relay ? (frame.hops_left - 8'd1) : 8'd0;
        result.start_deliver = start_hit;
    end

endmodule

`default_nettype wire

// File: design/mesh_flood_relay_filter_top.sv
// channel   direction  handshake                   word
// frame     in         frame_valid / frame_stall   frame_word_t, one parsed header
// result    out        result_valid / result_stall result_word_t, one per frame
// config    in         cfg_we, cfg_index, cfg_data one register per write
//
// a frame rejected on length or origin goes from ST_CHECK straight to ST_EMIT
// a frame that reaches the duplicate cache passes through ST_SCAN on its way to ST_EMIT:
// the cache compares one entry per cycle through a single comparator
// rst_n clears the sequencer, config and output valid registers, valid bits and ring pointer at once
// frame_stall is high from accept until the result is loaded into the output
// register; a stalled result holds there while the next frame is taken in
`default_nettype none

module mesh_flood_relay_filter_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  frame_valid,
    output logic                                       frame_stall,
    input  wire mfrf_pkg::frame_word_t                 frame,
    output logic                                       result_valid,
    input  wire logic                                  result_stall,
    output mfrf_pkg::result_word_t                     result,
    input  wire logic                                  cfg_we,
    input  wire logic [mfrf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [7:0]                            cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    mfrf_pkg::frame_word_t  frame_reg;
    mfrf_pkg::cfg_t         cfg_reg;
    logic [1:0]             verdict_reg, verdict_next;
    logic                   out_valid_reg;
    mfrf_pkg::result_word_t out_word_reg;
    mfrf_pkg::result_word_t decided;
    mfrf_pkg::scan_status_t scan_status;
    logic                   take;
    logic                   scan_start;
    logic                   out_free;
    logic                   emit;

    assign frame_stall  = (state_reg != ST_IDLE);
    assign take         = frame_valid && !frame_stall;
    assign out_free     = !out_valid_reg || !result_stall;
    assign emit         = (state_reg == ST_EMIT) && out_free;
    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        verdict_next = verdict_reg;
        scan_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (frame_reg.frame_length < mfrf_pkg::HEADER_BYTES)
                begin
                    verdict_next = mfrf_pkg::VERDICT_SHORT;
                    state_next   = ST_EMIT;
                end
                else if (frame_reg.origin_node == cfg_reg.own_node_id)
                begin
                    verdict_next = mfrf_pkg::VERDICT_OWN;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    scan_start = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_status.done)
                begin
                    verdict_next = scan_status.hit ? mfrf_pkg::VERDICT_DUP
                                                   : mfrf_pkg::VERDICT_ACCEPT;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    mfrf_pkg::REG_OWN_NODE:   cfg_reg.own_node_id      <= cfg_data;
                    mfrf_pkg::REG_OWN_TEAM:   cfg_reg.own_team_id      <= cfg_data;
                    mfrf_pkg::REG_PHONE:      cfg_reg.phone_linked     <= cfg_data[0];
                    mfrf_pkg::REG_START_ON:   cfg_reg.start_handler_on <= cfg_data[0];
                    mfrf_pkg::REG_STATE_CODE: cfg_reg.state_type_code  <= cfg_data;
                    mfrf_pkg::REG_START_CODE: cfg_reg.start_type_code  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
            frame_reg <= frame;
        verdict_reg <= verdict_next;
        if (emit)
            out_word_reg <= decided;
    end

    mfrf_cache u_cache (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (scan_start),
        .origin       (frame_reg.origin_node),
        .sequence_req (frame_reg.sequence_req),
        .status       (scan_status)
    );

    mfrf_decide u_decide (
        .frame   (frame_reg),
        .cfg     (cfg_reg),
        .verdict (verdict_reg),
        .result  (decided)
    );

endmodule

`default_nettype wire

// File: design/mfrf_check.sv
`default_nettype none

module mfrf_check (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  frame_valid,
    input  wire logic                                  frame_stall,
    input  wire logic                                  result_valid,
    input  wire logic                                  result_stall,
    input  wire mfrf_pkg::result_word_t                result
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // rejected frames carry no actions
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.verdict != mfrf_pkg::VERDICT_ACCEPT)
        |-> !result.to_phone && !result.do_relay && !result.start_deliver
            && (result.relay_hops == 8'd0))
        else $error("action on rejected frame");

    // hop count only when relaying, never from a zero ttl
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.do_relay || (result.relay_hops == 8'd0))
                         && (result.relay_hops != 8'hff))
        else $error("bad relay hop count");

    // block is busy right after taking a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_stall |=> frame_stall)
        else $error("frame taken while busy");

endmodule

bind mesh_flood_relay_filter_top mfrf_check u_mfrf_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
